// File: rtl/core/tccs_pkg.sv
// Package for the text console: geometry, character codes, op codes and row-cell control.
`default_nettype none
package tccs_pkg;

  localparam int SCREEN_W = 32;
  localparam int SCREEN_H = 30;

  localparam int COL_W    = $clog2(SCREEN_W);
  localparam int ROW_W    = $clog2(SCREEN_H);
  localparam int CNT_W    = $clog2(SCREEN_W + 1);
  localparam int CHAR_W   = 8;
  localparam int CURSOR_W = 5;
  localparam int COORD_W  = 8;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GOTO  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // What a row cell writes into its column store this cycle.
  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_PUT   = 2'd1,
    WR_SHIFT = 2'd2,
    WR_BLANK = 2'd3
  } wr_mode_e;

  typedef struct packed {
    wr_mode_e           mode;
    logic [COL_W-1:0]   waddr;
    logic [CHAR_W-1:0]  wdata;
    logic               rd_en;
    logic [COL_W-1:0]   raddr;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/tccs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tccs_row_cell.sv
// One screen row: column store plus write select (put, shift from row below, blank).
`default_nettype none
module tccs_row_cell (
  input  wire logic                          clk_i,
  input  wire tccs_pkg::cell_ctrl_t          ctrl_i,
  input  wire logic                          sel_i,
  input  wire logic [tccs_pkg::CHAR_W-1:0]   below_i,
  output logic      [tccs_pkg::CHAR_W-1:0]   rdata_o
);
  import tccs_pkg::*;

  logic              we;
  logic [CHAR_W-1:0] wdata;

  always_comb begin
    unique case (ctrl_i.mode)
      WR_PUT: begin
        we    = sel_i;
        wdata = ctrl_i.wdata;
      end
      WR_SHIFT: begin
        we    = 1'b1;
        wdata = below_i;
      end
      WR_BLANK: begin
        we    = 1'b1;
        wdata = BLANK_CHAR;
      end
      default: begin
        we    = 1'b0;
        wdata = ctrl_i.wdata;
      end
    endcase
  end

  tccs_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(SCREEN_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(ctrl_i.waddr),
    .wdata_i(wdata),
    .re_i   (ctrl_i.rd_en),
    .raddr_i(ctrl_i.raddr),
    .rdata_o(rdata_o)
  );

endmodule
`default_nettype wire

// File: rtl/core/text_console_cursor_scroll_unit.sv
// Top level of the text console: cursor, sequencer and the chain of row cells.
`default_nettype none
// Text console over a 32 x 30 character screen held as a chain of 30 row
// cells, each with its own 32-entry column RAM. One input beat carries an op:
// put char (0x0A is newline), goto, clear, or read cell. Every input beat
// yields exactly one output beat with the cursor after the op, the cell byte
// for a read (else 0) and a scrolled flag. Per beat: put and goto finish at
// the accepting edge (output valid the next cycle); read goes through one
// registered RAM read; clear homes the cursor, then blanks one column of all
// rows per cycle; a put that runs off the bottom row with scrolling enabled
// makes every row cell copy the row below it one column per cycle through the
// RAM read latency, the bottom cell taking blanks. After reset the block
// blanks the screen before it takes its first input beat. in_stall_o is high
// while an op is in progress or the output register holds a beat that is
// itself stalled. scroll_enable is written through cfg_we_i / cfg_wdata_i;
// the user must write it only while the block is idle, which the block itself
// does not enforce. When 0, a move past the last row homes the cursor and
// leaves the screen untouched.
module text_console_cursor_scroll_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_wdata_i,
  // input beat
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [tccs_pkg::CHAR_W-1:0]   ch_i,
  input  wire logic [tccs_pkg::COORD_W-1:0]  pos_x_i,
  input  wire logic [tccs_pkg::COORD_W-1:0]  pos_y_i,
  // output beat
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [tccs_pkg::CURSOR_W-1:0] cursor_col_o,
  output logic      [tccs_pkg::CURSOR_W-1:0] cursor_row_o,
  output logic      [tccs_pkg::CHAR_W-1:0]   cell_data_o,
  output logic                               scrolled_o
);
  import tccs_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_CLEAR  = 3'd3;
  localparam logic [2:0] ST_INIT   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [ROW_W-1:0]    rd_row_q, rd_row_d;
  logic                scroll_en_q;

  logic                out_valid_q;
  logic [CURSOR_W-1:0] out_col_q, out_row_q;
  logic [CHAR_W-1:0]   out_cell_q, out_cell;
  logic                out_scr_q, out_scr;
  logic                load_out;

  logic                in_acc;
  logic                out_busy;
  logic [COL_W-1:0]    x_cl;
  logic [ROW_W-1:0]    y_cl;
  logic [CNT_W-1:0]    cnt_prev;
  cell_ctrl_t          ctrl;

  logic [CHAR_W-1:0]   row_data [SCREEN_H];
  logic [SCREEN_H-1:0] row_sel;

  assign out_busy   = out_valid_q && out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || out_busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  // out-of-range coordinates fold to 0
  assign x_cl = (pos_x_i < COORD_W'(SCREEN_W)) ? pos_x_i[COL_W-1:0] : '0;
  assign y_cl = (pos_y_i < COORD_W'(SCREEN_H)) ? pos_y_i[ROW_W-1:0] : '0;

  assign cnt_prev = cnt_q - CNT_W'(1);

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    col_d      = col_q;
    row_d      = row_q;
    rd_row_d   = rd_row_q;
    load_out   = 1'b0;
    out_cell   = '0;
    out_scr    = 1'b0;
    ctrl.mode  = WR_NONE;
    ctrl.waddr = col_q;
    ctrl.wdata = ch_i;
    ctrl.rd_en = 1'b0;
    ctrl.raddr = '0;

    unique case (state_q) inside
      ST_IDLE: begin
        if (in_acc) begin
          case (op_i)
            OP_PUT: begin
              load_out = 1'b1;
              if (ch_i != NEWLINE_CHAR) begin
                ctrl.mode = WR_PUT;
              end
              if (ch_i == NEWLINE_CHAR || col_q == COL_W'(SCREEN_W - 1)) begin
                col_d = '0;
                if (row_q == ROW_W'(SCREEN_H - 1)) begin
                  if (scroll_en_q) begin
                    // result goes out when the row shift is done
                    load_out = 1'b0;
                    state_d  = ST_SCROLL;
                    cnt_d    = '0;
                  end else begin
                    row_d = '0;
                  end
                end else begin
                  row_d = row_q + ROW_W'(1);
                end
              end else begin
                col_d = col_q + COL_W'(1);
              end
            end
            OP_GOTO: begin
              col_d    = x_cl;
              row_d    = y_cl;
              load_out = 1'b1;
            end
            OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              state_d = ST_CLEAR;
              cnt_d   = '0;
            end
            OP_READ: begin
              ctrl.rd_en = 1'b1;
              ctrl.raddr = x_cl;
              rd_row_d   = y_cl;
              state_d    = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        load_out = 1'b1;
        out_cell = row_data[rd_row_q];
        state_d  = ST_IDLE;
      end
      ST_SCROLL: begin
        // read column cnt, write column cnt-1 from the row below
        if (cnt_q != CNT_W'(SCREEN_W)) begin
          ctrl.rd_en = 1'b1;
          ctrl.raddr = cnt_q[COL_W-1:0];
        end
        if (cnt_q != '0) begin
          ctrl.mode  = WR_SHIFT;
          ctrl.waddr = cnt_prev[COL_W-1:0];
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SCREEN_W)) begin
          load_out = 1'b1;
          out_scr  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_CLEAR, ST_INIT: begin
        ctrl.mode  = WR_BLANK;
        ctrl.waddr = cnt_q[COL_W-1:0];
        cnt_d      = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SCREEN_W - 1)) begin
          load_out = (state_q == ST_CLEAR);
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      rd_row_q    <= '0;
      scroll_en_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      col_q    <= col_d;
      row_q    <= row_d;
      rd_row_q <= rd_row_d;
      if (cfg_we_i) begin
        scroll_en_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_col_q  <= CURSOR_W'(col_d);
      out_row_q  <= CURSOR_W'(row_d);
      out_cell_q <= out_cell;
      out_scr_q  <= out_scr;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign cell_data_o  = out_cell_q;
  assign scrolled_o   = out_scr_q;

  // chain of row cells; each takes the row below during a scroll
  for (genvar r = 0; r < SCREEN_H; r++) begin : g_row
    logic [CHAR_W-1:0] below;

    if (r == SCREEN_H - 1) begin : g_bottom
      assign below = BLANK_CHAR;
    end else begin : g_inner
      assign below = row_data[r+1];
    end

    assign row_sel[r] = (row_q == ROW_W'(r));

    tccs_row_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .sel_i  (row_sel[r]),
      .below_i(below),
      .rdata_o(row_data[r])
    );
  end

  // checks
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !out_busy)
    else $error("output beat overwritten while stalled");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && scrolled_o) |->
      (cursor_row_o == CURSOR_W'(SCREEN_H - 1) && cursor_col_o == '0))
    else $error("scroll result with cursor off the bottom row start");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL || state_q == ST_CLEAR || state_q == ST_INIT) |->
      cnt_q <= CNT_W'(SCREEN_W))
    else $error("sweep counter ran past the row length");

  a_read_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op_i == OP_READ) |=> (state_q == ST_READ && !out_valid_q))
    else $error("read did not enter its data cycle with a free output slot");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < ROW_W'(SCREEN_H))
    else $error("cursor row out of range");

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the text console: cursor moves, wrap, scroll, home, clear, reads.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tccs_pkg::*;

  localparam int CELLS          = SCREEN_W * SCREEN_H;
  // Scrolls and clears hold the input for a whole row sweep; output stalls add more.
  // Nothing should ever sit this long without a beat moving.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int IDLE_PCT       = 35;

  // One output beat: cursor after the op, cell byte for a read, scroll flag.
  typedef struct packed {
    logic [CURSOR_W-1:0] col;
    logic [CURSOR_W-1:0] row;
    logic [CHAR_W-1:0]   cell_byte;
    logic                scrolled;
  } console_beat_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs; every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic               clk_i     = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               in_valid  = 1'b0;
  op_e                op_d      = OP_PUT;
  logic [CHAR_W-1:0]  ch_d      = '0;
  logic [COORD_W-1:0] pos_x_d   = '0;
  logic [COORD_W-1:0] pos_y_d   = '0;
  logic               out_stall = 1'b0;

  logic                in_stall;
  logic                out_valid;
  logic [CURSOR_W-1:0] cursor_col;
  logic [CURSOR_W-1:0] cursor_row;
  logic [CHAR_W-1:0]   cell_data;
  logic                scrolled;

  // Percentage of cycles in which each side idles; zero for the burst phase.
  int unsigned idle_pct = IDLE_PCT;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  text_console_cursor_scroll_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op_d),
    .ch_i        (ch_d),
    .pos_x_i     (pos_x_d),
    .pos_y_i     (pos_y_d),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .cursor_col_o(cursor_col),
    .cursor_row_o(cursor_row),
    .cell_data_o (cell_data),
    .scrolled_o  (scrolled)
  );

  // ---------------------------------------------------------------------------
  // Shadow console: own copy of the screen, cursor and scroll mode.
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0] screen_mirror [CELLS];
  int unsigned       mirror_col;
  int unsigned       mirror_row;
  bit                mirror_scroll_en;

  console_beat_t expected_beats[$];

  // Run statistics for the closing summary.
  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned puts_seen;
  int unsigned scrolls_seen;
  int unsigned homes_seen;
  int unsigned reads_seen;
  int unsigned clears_seen;
  int unsigned errors;
  int unsigned idle_cycles;

  function automatic void blank_mirror();
    for (int i = 0; i < CELLS; i++) screen_mirror[i] = BLANK_CHAR;
  endfunction

  // Move to column 0 of the next row; past the bottom either scroll the
  // screen up with a blank bottom row, or home the cursor and keep the screen.
  function automatic bit mirror_next_row();
    mirror_col = 0;
    mirror_row++;
    if (mirror_row < SCREEN_H) return 1'b0;
    if (mirror_scroll_en) begin
      for (int i = 0; i < CELLS - SCREEN_W; i++) screen_mirror[i] = screen_mirror[i + SCREEN_W];
      for (int i = CELLS - SCREEN_W; i < CELLS; i++) screen_mirror[i] = BLANK_CHAR;
      mirror_row = SCREEN_H - 1;
      scrolls_seen++;
      return 1'b1;
    end
    mirror_row = 0;
    homes_seen++;
    return 1'b0;
  endfunction

  // Apply one accepted op to the shadow console and return the beat it owes.
  function automatic console_beat_t predict_console_op(op_e op, logic [CHAR_W-1:0] ch,
                                                       logic [COORD_W-1:0] x,
                                                       logic [COORD_W-1:0] y);
    int unsigned   px;
    int unsigned   py;
    console_beat_t beat;
    // Coordinates off the screen fold to 0 on each axis separately.
    px   = (x < SCREEN_W) ? x : 0;
    py   = (y < SCREEN_H) ? y : 0;
    beat = '0;
    case (op)
      OP_PUT: begin
        puts_seen++;
        if (ch == NEWLINE_CHAR) begin
          // Newline writes nothing, it only moves the cursor.
          beat.scrolled = mirror_next_row();
        end else begin
          screen_mirror[mirror_row * SCREEN_W + mirror_col] = ch;
          mirror_col++;
          if (mirror_col >= SCREEN_W) beat.scrolled = mirror_next_row();
        end
      end
      OP_GOTO: begin
        mirror_col = px;
        mirror_row = py;
      end
      OP_CLEAR: begin
        clears_seen++;
        blank_mirror();
        mirror_col = 0;
        mirror_row = 0;
      end
      default: begin
        // Read leaves the cursor where it is.
        reads_seen++;
        beat.cell_byte = screen_mirror[py * SCREEN_W + px];
      end
    endcase
    beat.col = mirror_col[CURSOR_W-1:0];
    beat.row = mirror_row[CURSOR_W-1:0];
    return beat;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Payload changes only on the edge that accepts a beat, so a
  // stalled beat holds still; idle gaps drop valid for whole cycles.
  // ---------------------------------------------------------------------------
  task automatic send_console_op(op_e op, logic [CHAR_W-1:0] ch,
                                 logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op_d     <= op;
    ch_d     <= ch;
    pos_x_d  <= x;
    pos_y_d  <= y;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    expected_beats.push_back(predict_console_op(op, ch, x, y));
    beats_sent++;
  endtask

  // Drop valid and wait until every owed beat has come back and the block
  // takes input again.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0 || in_stall !== 1'b0);
  endtask

  // scroll_enable changes only while the block is idle.
  task automatic write_scroll_enable(bit en);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk_i);
    mirror_scroll_en = en;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, and each accepted beat is checked against
  // the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk_i) begin
    console_beat_t got;
    console_beat_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got = {cursor_col, cursor_row, cell_data, scrolled};
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat with nothing owed: col %0d row %0d cell %02h scrolled %0b",
                   $realtime, got.col, got.row, got.cell_byte, got.scrolled);
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (got.col !== want.col || got.row !== want.row ||
            got.cell_byte !== want.cell_byte || got.scrolled !== want.scrolled) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: beat %0d mismatch: col %0d/%0d row %0d/%0d cell %02h/%02h scrl %0b/%0b",
                     $realtime, beats_checked, want.col, got.col, want.row, got.row,
                     want.cell_byte, got.cell_byte, want.scrolled, got.scrolled);
        end
      end
    end
  end

  // Watchdog: too long with no beat moving on either side ends the run.
  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d results still owed",
                 $realtime, idle_cycles, expected_beats.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh screen reads as blanks, including through folded coordinates.
  task automatic test_reset_contents();
    write_scroll_enable(1'b1);
    send_console_op(OP_READ, 8'h00, 8'd0, 8'd0);
    send_console_op(OP_READ, 8'hFF, 8'd31, 8'd29);
    send_console_op(OP_READ, 8'h00, 8'd255, 8'd255);
    send_console_op(OP_READ, 8'h00, 8'd32, 8'd30);
  endtask

  // Byte extremes, wrap off the last column, scroll by wrap and by newline,
  // goto with each axis out of range.
  task automatic test_put_wrap_scroll();
    send_console_op(OP_PUT, 8'h00, 8'd0, 8'd0);
    send_console_op(OP_PUT, 8'hFF, 8'hFF, 8'hFF);
    send_console_op(OP_GOTO, 8'h00, 8'd31, 8'd29);
    send_console_op(OP_PUT, 8'h41, 8'd0, 8'd0);
    send_console_op(OP_READ, 8'h00, 8'd31, 8'd28);
    send_console_op(OP_PUT, NEWLINE_CHAR, 8'd0, 8'd0);
    send_console_op(OP_GOTO, 8'h00, 8'd32, 8'd30);
    send_console_op(OP_GOTO, 8'h00, 8'd5, 8'd255);
  endtask

  // Clear blanks everything and homes the cursor.
  task automatic test_clear();
    send_console_op(OP_CLEAR, 8'hAA, 8'd17, 8'd9);
    send_console_op(OP_READ, 8'h00, 8'd31, 8'd27);
  endtask

  // With scrolling off, running past the bottom homes and keeps the screen.
  task automatic test_home_at_bottom();
    write_scroll_enable(1'b0);
    send_console_op(OP_GOTO, 8'h00, 8'd31, 8'd29);
    send_console_op(OP_PUT, 8'h5A, 8'd0, 8'd0);
    send_console_op(OP_READ, 8'h00, 8'd31, 8'd29);
    send_console_op(OP_GOTO, 8'h00, 8'd0, 8'd29);
    send_console_op(OP_PUT, NEWLINE_CHAR, 8'd0, 8'd0);
    send_console_op(OP_PUT, NEWLINE_CHAR, 8'd0, 8'd0);
  endtask

  // Mostly in range, now and then any byte so every coordinate bit toggles.
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned span);
    if ($urandom_range(99) < 15) return COORD_W'($urandom_range(255));
    return COORD_W'($urandom_range(span - 1));
  endfunction

  // Random ops weighted toward text: puts dominate, gotos lean to the bottom
  // rows so that wraps and newlines run off the screen often.
  task automatic run_random_ops(int unsigned count);
    int unsigned        pick;
    logic [CHAR_W-1:0]  ch;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    repeat (count) begin
      pick = $urandom_range(99);
      ch   = ($urandom_range(9) == 0) ? NEWLINE_CHAR : CHAR_W'($urandom_range(255));
      x    = pick_coord(SCREEN_W);
      y    = ($urandom_range(1) == 0) ? COORD_W'($urandom_range(SCREEN_H - 1, SCREEN_H - 3))
                                      : pick_coord(SCREEN_H);
      if (pick < 62)      send_console_op(OP_PUT, ch, x, y);
      else if (pick < 76) send_console_op(OP_GOTO, ch, x, y);
      else if (pick < 79) send_console_op(OP_CLEAR, ch, x, y);
      else                send_console_op(OP_READ, ch, x, y);
    end
  endtask

  task automatic test_random_scrolling();
    write_scroll_enable(1'b1);
    run_random_ops(300);
  endtask

  task automatic test_random_homing();
    write_scroll_enable(1'b0);
    run_random_ops(250);
  endtask

  // Long stretch with both sides always ready.
  task automatic test_back_to_back();
    write_scroll_enable(1'b1);
    idle_pct = 0;
    run_random_ops(250);
    idle_pct = IDLE_PCT;
  endtask

  initial begin
    blank_mirror();
    mirror_col       = 0;
    mirror_row       = 0;
    mirror_scroll_en = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;

    test_reset_contents();
    test_put_wrap_scroll();
    test_clear();
    test_home_at_bottom();
    test_random_scrolling();
    test_random_homing();
    test_back_to_back();

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d ops (%0d puts, %0d reads, %0d clears), %0d results checked.",
             beats_sent, puts_seen, reads_seen, clears_seen, beats_checked);
    $display("Bottom-row overruns: %0d scrolled, %0d homed; %0d failures.",
             scrolls_seen, homes_seen, errors);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
